// ----- rtl/isat_pkg.sv -----
// Shared codes, types and constants for the indexed shift array table.
package isat_pkg;

   localparam int DATA_W  = 32;
   localparam int IDX_W   = 4;
   localparam int ACT_W   = 3;
   localparam int STS_W   = 2;
   localparam int LEN_W   = 5;

   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

   localparam logic [STS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STS_W-1:0] STS_BOUNDS  = 2'd1;
   localparam logic [STS_W-1:0] STS_MISSING = 2'd2;

   localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic scan_step;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_find;
      logic scan_done;
   } dp_status_type;

endpackage

// ----- rtl/isat_controller.sv -----
// Sequencing state machine for the indexed shift array table.
module isat_controller
   import isat_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctl_cmd_type   cmd,
   input  dp_status_type sts
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.execute   = (state_ff == ST_EXEC);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.load_rsp  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.is_find ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.load_rsp) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the beat while the far side stalls
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/isat_datapath.sv -----
// Entry store, shift network, match scan and result registers.
module isat_datapath
   import isat_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [IDX_W-1:0]         req_index,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     csr_wr_en,
   input  logic [LEN_W-1:0]         csr_wr_data,
   input  ctl_cmd_type              cmd,
   output dp_status_type            sts,
   output logic [STS_W-1:0]         rsp_status,
   output logic [IDX_W-1:0]         rsp_position,
   output logic signed [DATA_W-1:0] rsp_data
);

   localparam int NW = $clog2(DEPTH + 1);
   localparam int LW = (NW > LEN_W) ? NW : LEN_W;
   localparam int IW = $clog2(DEPTH);

   logic [ACT_W-1:0]  act_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] val_ff;
   logic [LEN_W-1:0]  len_ff;

   logic [DATA_W-1:0] cell_ff [DEPTH];
   logic [DATA_W-1:0] cell_in [DEPTH];

   logic [DEPTH-1:0]  mvec_ff, mvec_in;
   logic [IW-1:0]     cnt_ff;

   logic [STS_W-1:0]  res_status_ff;
   logic [IDX_W-1:0]  res_pos_ff;
   logic [DATA_W-1:0] res_data_ff;

   logic [STS_W-1:0]  rsp_status_ff;
   logic [IDX_W-1:0]  rsp_pos_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   logic [LW-1:0]     len_ext, used_len, idx_ext;
   logic              in_range, modify;
   logic [DATA_W-1:0] rd_data;

   // saturate the programmed length to the store depth
   assign len_ext  = LW'(len_ff);
   assign used_len = (len_ext > LW'(DEPTH)) ? LW'(DEPTH) : len_ext;
   assign idx_ext  = LW'(idx_ff);
   assign in_range = idx_ext < used_len;
   assign modify   = cmd.execute && in_range;

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (idx_ext == LW'(i)) rd_data = rd_data | cell_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         mvec_in[i] = (cell_ff[i] == val_ff) && (LW'(i) < used_len);
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int PREV = (g == 0) ? 0 : g - 1;
      localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;
      always_comb begin
         cell_in[g] = cell_ff[g];
         if (modify) begin
            case (act_ff)
               ACT_INSERT: begin
                  if (idx_ext == LW'(g)) begin
                     cell_in[g] = val_ff;
                  end else if ((LW'(g) > idx_ext) && (LW'(g) < used_len)) begin
                     cell_in[g] = cell_ff[PREV];
                  end
               end
               ACT_DELETE: begin
                  if ((LW'(g) >= idx_ext) && (LW'(g + 1) < used_len)) begin
                     cell_in[g] = cell_ff[NEXT];
                  end
               end
               ACT_UPDATE: begin
                  if (idx_ext == LW'(g)) cell_in[g] = val_ff;
               end
               default: begin
                  cell_in[g] = cell_ff[g];
               end
            endcase
         end
      end
   end

   assign sts.is_find   = (act_ff == ACT_FIND);
   assign sts.scan_done = mvec_ff[cnt_ff] || (cnt_ff == IW'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
         for (int i = 0; i < DEPTH; i++) cell_ff[i] <= '0;
      end else begin
         if (csr_wr_en) len_ff <= csr_wr_data;
         for (int i = 0; i < DEPTH; i++) cell_ff[i] <= cell_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         idx_ff <= req_index;
         val_ff <= req_value;
      end
      if (cmd.execute) begin
         mvec_ff       <= mvec_in;
         cnt_ff        <= '0;
         res_status_ff <= ((act_ff <= ACT_READ) && !in_range) ? STS_BOUNDS : STS_OK;
         res_pos_ff    <= idx_ff;
         res_data_ff   <= ((act_ff == ACT_READ) && in_range) ? rd_data : '0;
      end
      if (cmd.scan_step) begin
         if (mvec_ff[cnt_ff]) begin
            res_status_ff <= STS_OK;
            res_pos_ff    <= IDX_W'(cnt_ff);
            res_data_ff   <= '0;
         end else if (cnt_ff == IW'(DEPTH - 1)) begin
            res_status_ff <= STS_MISSING;
            res_pos_ff    <= '0;
            res_data_ff   <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

// ----- rtl/indexed_shift_array_table.sv -----
// Top level of the indexed shift array table: controller plus datapath.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_action, req_index, req_value
//   rsp       out        rsp_valid / rsp_stall  rsp_status, rsp_position, rsp_data
//   csr       in         csr_wr_en              csr_wr_data (length in use)
//
// One request at a time. Insert, delete, update, read and unused codes step
// through capture, execute and result load before the next accept.
// Find adds a scan of the registered match vector, one entry a cycle, between
// execute and result load; the scan ends at the first hit or the last entry.
// A stall on rsp holds the result beat; the next request may still be taken,
// and the controller then waits in the result load until the held beat leaves.
// Synchronous reset clears every entry and sets length to 16.
module indexed_shift_array_table
   import isat_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [IDX_W-1:0]         req_index,
   input  logic signed [DATA_W-1:0] req_value,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STS_W-1:0]         rsp_status,
   output logic [IDX_W-1:0]         rsp_position,
   output logic signed [DATA_W-1:0] rsp_data,
   // length register
   input  logic                     csr_wr_en,
   input  logic [LEN_W-1:0]         csr_wr_data
);

   ctl_cmd_type   cmd;
   dp_status_type sts;

   // sequence each request: capture, execute, scan for find, load result
   isat_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // hold the entries, shift them in parallel, search and register the result
   isat_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_action   (req_action),
      .req_index    (req_index),
      .req_value    (req_value),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_data     (rsp_data)
   );

endmodule

// ----- rtl/isat_checker.sv -----
// Port-level checks for the indexed shift array table, bound to the top level.
module isat_checker
   import isat_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [STS_W-1:0]         rsp_status,
   input logic [IDX_W-1:0]         rsp_position,
   input logic signed [DATA_W-1:0] rsp_data
);

   // one request at a time: stall follows every accepted beat
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted on consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STS_OK || rsp_status == STS_BOUNDS ||
                     rsp_status == STS_MISSING))
      else $error("undefined status code");

   a_bounds_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_BOUNDS) |-> (rsp_data == '0))
      else $error("out-of-bounds result carries data");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_MISSING) |-> (rsp_position == '0 && rsp_data == '0))
      else $error("not-found result carries position or data");

endmodule

bind indexed_shift_array_table isat_checker u_isat_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position),
   .rsp_data     (rsp_data)
);
